// ----- rtl/core/nec_ir_pkg.sv -----
// Shared definitions for the NEC infrared frame decoder core.
// Holds register indexes, reset values, status codes and the range check.
// No dependencies.
package nec_ir_pkg;

    // widths of the stream fields
    localparam int DUR_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int BITS_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 24;

    // frame layout
    localparam int FRAME_PULSES = 67;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;
    localparam logic [COUNT_W-1:0] IDX_LDR_BURST = 7'd0;
    localparam logic [COUNT_W-1:0] IDX_LDR_SPACE = 7'd1;
    localparam logic [COUNT_W-1:0] IDX_DATA_FIRST = 7'd2;
    localparam logic [COUNT_W-1:0] IDX_DATA_LAST  = 7'd65;
    localparam logic [COUNT_W-1:0] REPEAT_PULSES  = 7'd3;
    localparam logic [BYTE_W:0]    ADDR_OFFSET    = 9'h010;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_BURST = 3'd0,
        CFG_LEADER_SPACE = 3'd1,
        CFG_BIT_BURST    = 3'd2,
        CFG_ONE_SPACE    = 3'd3,
        CFG_REPEAT_SPACE = 3'd4,
        CFG_TOLERANCE    = 3'd5
    } cfg_idx_t;

    // register reset values
    localparam logic [DUR_W-1:0] RST_LEADER_BURST = 16'd9000;
    localparam logic [DUR_W-1:0] RST_LEADER_SPACE = 16'd4500;
    localparam logic [DUR_W-1:0] RST_BIT_BURST    = 16'd562;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1687;
    localparam logic [DUR_W-1:0] RST_REPEAT_SPACE = 16'd2250;
    localparam logic [DUR_W-1:0] RST_TOLERANCE    = 16'd200;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL   = 3'd0,
        ST_REPEAT   = 3'd1,
        ST_NOT_NEC  = 3'd2,
        ST_ADDR_BAD = 3'd3,
        ST_CMD_BAD  = 3'd4
    } status_t;

    // duration within nominal +/- tolerance, widened so nothing wraps
    function automatic logic near_value(
        input logic [DUR_W-1:0] d,
        input logic [DUR_W-1:0] n,
        input logic [DUR_W-1:0] e
    );
        logic [DUR_W:0] d_plus_e;
        logic [DUR_W:0] n_plus_e;
        d_plus_e = {1'b0, d} + {1'b0, e};
        n_plus_e = {1'b0, n} + {1'b0, e};
        return (d_plus_e >= {1'b0, n}) && ({1'b0, d} <= n_plus_e);
    endfunction

endpackage

// ----- rtl/core/nec_ir_frame_decoder_core.sv -----
// NEC infrared frame decoder core, top level.
// Depends on nec_ir_pkg for field widths, register indexes and status codes.
//
// Usage:
// - s_ channel: one beat per captured burst or space duration; s_tlast marks
//   the last duration of a frame.
// - m_ channel: one result beat per frame, sent for the beat that had s_tlast.
// - cfg channel: register writes (index, 16-bit data), always ready; write
//   only while no frame beat is still in flight.
// Order: each beat is checked while in the input register; a frame's result shows on
// m_tvalid once the result register takes it. Throughput: one beat per cycle unless a
// frame-end beat waits. Each beat passes an input register, one level of range compares
// and bit insertion, then frame state registers or, at frame end, the result register.
// Stall: beats that do not end a frame keep flowing while m_ stalls; a
// frame-end beat waits in the input register until the result register is
// free, and s_tready drops while it waits.
// Reset: frame state clears, registers return to the NEC nominal timings,
// both channels go empty.
module nec_ir_frame_decoder_core #(
    parameter int FRAME_PULSES = nec_ir_pkg::FRAME_PULSES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input durations
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nec_ir_pkg::DUR_W-1:0]      s_tdata,  // [15:0] duration_us
    input  logic                              s_tlast,  // frame_end
    // frame results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nec_ir_pkg::OUT_W-1:0]      m_tdata,  // [2:0] status, [10:3] address,
                                                        // [18:11] command_code, rest zero
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nec_ir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nec_ir_pkg::DUR_W-1:0]      cfg_data
);
    import nec_ir_pkg::*;

    // configuration registers
    logic [DUR_W-1:0] leader_burst_reg;
    logic [DUR_W-1:0] leader_space_reg;
    logic [DUR_W-1:0] bit_burst_reg;
    logic [DUR_W-1:0] one_space_reg;
    logic [DUR_W-1:0] repeat_space_reg;
    logic [DUR_W-1:0] tolerance_reg;

    // input register
    logic             in_valid_reg;
    logic [DUR_W-1:0] in_dur_reg;
    logic             in_last_reg;

    // frame state
    logic [COUNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic [BITS_W-1:0]  bits_reg, bits_next;
    logic               leader_ok_reg, leader_ok_next;
    logic               repeat_ok_reg, repeat_ok_next;
    logic               burst_ok_reg, burst_ok_next;

    // result register
    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic [BYTE_W-1:0]  addr_reg, addr_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;

    logic advance;
    logic near_lb, near_ls, near_rs, near_bb, near_os;
    logic [COUNT_W-1:0] rel;
    logic [4:0]         bit_pos;
    logic [BYTE_W-1:0]  b_addr, b_inv_addr, b_cmd, b_inv_cmd, comp;

    // handshake: only a frame-end beat needs the result register
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leader_burst_reg <= RST_LEADER_BURST;
            leader_space_reg <= RST_LEADER_SPACE;
            bit_burst_reg    <= RST_BIT_BURST;
            one_space_reg    <= RST_ONE_SPACE;
            repeat_space_reg <= RST_REPEAT_SPACE;
            tolerance_reg    <= RST_TOLERANCE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LEADER_BURST: leader_burst_reg <= cfg_data;
                CFG_LEADER_SPACE: leader_space_reg <= cfg_data;
                CFG_BIT_BURST:    bit_burst_reg    <= cfg_data;
                CFG_ONE_SPACE:    one_space_reg    <= cfg_data;
                CFG_REPEAT_SPACE: repeat_space_reg <= cfg_data;
                CFG_TOLERANCE:    tolerance_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_dur_reg  <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // range checks against each nominal
    assign near_lb = near_value(in_dur_reg, leader_burst_reg, tolerance_reg);
    assign near_ls = near_value(in_dur_reg, leader_space_reg, tolerance_reg);
    assign near_rs = near_value(in_dur_reg, repeat_space_reg, tolerance_reg);
    assign near_bb = near_value(in_dur_reg, bit_burst_reg, tolerance_reg);
    assign near_os = near_value(in_dur_reg, one_space_reg, tolerance_reg);

    assign rel     = pulse_count_reg - IDX_DATA_FIRST;
    assign bit_pos = rel[5:1];

    // frame state update for the beat in the input register
    always_comb begin
        leader_ok_next = leader_ok_reg;
        repeat_ok_next = repeat_ok_reg;
        burst_ok_next  = burst_ok_reg;
        bits_next      = bits_reg;

        if (pulse_count_reg == IDX_LDR_BURST) begin
            leader_ok_next = leader_ok_reg && near_lb;
            repeat_ok_next = repeat_ok_reg && near_lb;
        end else if (pulse_count_reg == IDX_LDR_SPACE) begin
            leader_ok_next = leader_ok_reg && near_ls;
            repeat_ok_next = repeat_ok_reg && near_rs;
        end
        if (pulse_count_reg == IDX_DATA_FIRST) begin
            repeat_ok_next = repeat_ok_reg && near_bb;
        end

        // data pairs: burst sets the flag, space completes the bit
        if (pulse_count_reg >= IDX_DATA_FIRST && pulse_count_reg <= IDX_DATA_LAST) begin
            if (!rel[0]) begin
                burst_ok_next = near_bb;
            end else if (burst_ok_reg && near_os) begin
                bits_next = bits_reg | (BITS_W'(1) << bit_pos);
            end
        end

        if (pulse_count_reg != COUNT_MAX) begin
            pulse_count_next = pulse_count_reg + 7'd1;
        end else begin
            pulse_count_next = pulse_count_reg;
        end
    end

    // frame decision on the last beat
    assign b_addr     = bits_next[BYTE_W-1:0];
    assign b_inv_addr = bits_next[2*BYTE_W-1:BYTE_W];
    assign b_cmd      = bits_next[3*BYTE_W-1:2*BYTE_W];
    assign b_inv_cmd  = bits_next[4*BYTE_W-1:3*BYTE_W];
    assign comp       = ~b_addr;

    always_comb begin
        if (pulse_count_next == REPEAT_PULSES && repeat_ok_next) begin
            status_next = ST_REPEAT;
        end else if (pulse_count_next < COUNT_W'(FRAME_PULSES) || !leader_ok_next) begin
            status_next = ST_NOT_NEC;
        end else if (comp != b_inv_addr &&
                     {1'b0, comp} != ({1'b0, b_inv_addr} + ADDR_OFFSET)) begin
            status_next = ST_ADDR_BAD;
        end else if (~b_cmd != b_inv_cmd) begin
            status_next = ST_CMD_BAD;
        end else begin
            status_next = ST_NORMAL;
        end
        addr_next = (status_next == ST_NORMAL) ? b_addr : '0;
        cmd_next  = (status_next == ST_NORMAL) ? b_cmd : '0;
    end

    // frame state registers, cleared after each result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_count_reg <= '0;
            bits_reg        <= '0;
            leader_ok_reg   <= 1'b1;
            repeat_ok_reg   <= 1'b1;
            burst_ok_reg    <= 1'b0;
        end else if (advance) begin
            if (in_last_reg) begin
                pulse_count_reg <= '0;
                bits_reg        <= '0;
                leader_ok_reg   <= 1'b1;
                repeat_ok_reg   <= 1'b1;
                burst_ok_reg    <= 1'b0;
            end else begin
                pulse_count_reg <= pulse_count_next;
                bits_reg        <= bits_next;
                leader_ok_reg   <= leader_ok_next;
                repeat_ok_reg   <= repeat_ok_next;
                burst_ok_reg    <= burst_ok_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, cmd_reg, addr_reg, status_reg};

    // checks
    a_last_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> out_valid_reg)
        else $error("frame-end beat did not produce a result");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> pulse_count_reg == '0 && bits_reg == '0)
        else $error("frame state not cleared after result");

    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && in_last_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked frame-end beat");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && status_reg != ST_NORMAL |-> addr_reg == '0 && cmd_reg == '0)
        else $error("address or command set on a non-normal result");

endmodule
